// ===== sv/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg: point-triangle distance shared types and constants
// Widths, stage map, payload structs and wide multiply helpers.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int CW    = 24;             // coordinate width
  localparam int EW    = CW + 1;         // edge / difference width
  localparam int PW    = 2 * EW;         // product of two differences
  localparam int DW    = PW + 1;         // dot product width
  localparam int HW    = (DW - 1) / 2;   // half of a dot magnitude
  localparam int WW    = 2 * DW + 2;     // wide product / numerator width
  localparam int SW    = DW + 3;         // small sums of dot products
  localparam int QF    = 16;             // parameter fraction bits
  localparam int QW    = QF + 1;
  localparam logic [QW-1:0] PONE = QW'(1) << QF;
  localparam int PMW   = EW + QW + 1;    // edge times parameter
  localparam int PSW   = PMW + 2;        // closest point accumulator
  localparam int SQW   = 2 * CW;         // squared axis distance
  localparam int DSQW  = 2 * CW + 2;     // squared distance
  localparam int DISTW = CW + 2;         // distance
  localparam int SQ_XW = DSQW;
  localparam int SQ_RW = SQ_XW + 1;
  localparam int SQ_IT = SQ_XW / 2;      // root bits

  localparam int DIV_STEPS = 2;
  localparam int DIV_NST   = 1 + QF / DIV_STEPS;
  localparam int SQ_STEPS  = 2;
  localparam int SQRT_NST  = (SQ_IT + SQ_STEPS - 1) / SQ_STEPS;

  localparam int ST_IN    = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_DOT   = 2;
  localparam int ST_PART  = 3;
  localparam int ST_WIDE  = 4;
  localparam int ST_NUM   = 5;
  localparam int ST_CLS   = 6;
  localparam int ST_DIV0  = 7;
  localparam int ST_ST    = ST_DIV0 + DIV_NST;
  localparam int ST_PMUL  = ST_ST + 1;
  localparam int ST_CLOSE = ST_ST + 2;
  localparam int ST_SQ    = ST_ST + 3;
  localparam int ST_SUM   = ST_ST + 4;
  localparam int ST_SQRT0 = ST_ST + 5;
  localparam int NST      = ST_SQRT0 + SQRT_NST;
  localparam int LAST     = NST - 1;

  typedef enum logic [2:0] {
    RG_FACE    = 3'd0,
    RG_EDGE_ST = 3'd1,
    RG_VERT2   = 3'd2,
    RG_EDGE_S0 = 3'd3,
    RG_VERT0   = 3'd4,
    RG_EDGE_T0 = 3'd5,
    RG_VERT1   = 3'd6
  } region_t;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_z;
  } in_t;

  typedef struct packed {
    logic [DISTW-1:0]     distance;
    logic [DSQW-1:0]      distance_sq;
    logic signed [CW-1:0] closest_x;
    logic signed [CW-1:0] closest_y;
    logic signed [CW-1:0] closest_z;
    logic [QW-1:0]        param_s;
    logic [QW-1:0]        param_t;
    region_t              region;
    logic                 degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0][CW-1:0] v0;
    logic [2:0][CW-1:0] q;
    logic [2:0][EW-1:0] e0;
    logic [2:0][EW-1:0] e1;
    logic [2:0][EW-1:0] w;
  } geo_t;

  typedef struct packed {
    logic [2:0][PW-1:0] a;
    logic [2:0][PW-1:0] b;
    logic [2:0][PW-1:0] c;
    logic [2:0][PW-1:0] d;
    logic [2:0][PW-1:0] e;
  } prod_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] e;
  } dot_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] nd;
    logic signed [DW-1:0] ne;
    logic                 dneg;
    logic signed [SW-1:0] den2;
    logic signed [SW-1:0] r2_df;
    logic                 r2_gt;
    logic                 r2_le0;
    logic signed [SW-1:0] r6_df;
    logic                 r6_gt;
    logic                 r6_le0;
  } aux_t;

  typedef struct packed {
    logic                neg;
    logic [2*HW-1:0]     ll;
    logic [2*HW-1:0]     lh;
    logic [2*HW-1:0]     hl;
    logic [2*HW-1:0]     hh;
  } part_t;

  typedef struct packed {
    logic signed [WW-1:0] det;
    logic signed [WW-1:0] sn;
    logic signed [WW-1:0] tn;
  } num_t;

  typedef struct packed {
    logic signed [WW-1:0] num;
    logic signed [WW-1:0] den;
  } div_in_t;

  typedef struct packed {
    region_t region;
    logic    degen;
    logic    s_comp;
    logic    t_comp;
  } cls_t;

  function automatic logic signed [PW-1:0] smul(input logic signed [EW-1:0] x,
                                                input logic signed [EW-1:0] y);
    return x * y;
  endfunction

  function automatic logic signed [DW-1:0] sum3(input logic [2:0][PW-1:0] p);
    return DW'($signed(p[0])) + DW'($signed(p[1])) + DW'($signed(p[2]));
  endfunction

  function automatic part_t mul_part(input logic signed [DW-1:0] x,
                                     input logic signed [DW-1:0] y);
    logic [DW-1:0] mx;
    logic [DW-1:0] my;
    part_t         p;
    mx = x[DW-1] ? DW'(-x) : DW'(x);
    my = y[DW-1] ? DW'(-y) : DW'(y);
    p.neg = x[DW-1] ^ y[DW-1];
    p.ll  = mx[HW-1:0] * my[HW-1:0];
    p.lh  = mx[HW-1:0] * my[2*HW-1:HW];
    p.hl  = mx[2*HW-1:HW] * my[HW-1:0];
    p.hh  = mx[2*HW-1:HW] * my[2*HW-1:HW];
    return p;
  endfunction

  function automatic logic signed [WW-1:0] mul_join(input part_t p);
    logic [WW-1:0] m;
    m = (WW'(p.hh) << (2 * HW)) + (WW'(p.lh) << HW) + (WW'(p.hl) << HW) + WW'(p.ll);
    return p.neg ? $signed(WW'(-m)) : $signed(m);
  endfunction

endpackage

// ===== sv/ptd_div.sv =====
// ----------------------------------------------------------------------------
// ptd_div: pipelined clamped fraction divider
// Gives num/den clamped to [0,1] in Q1.16, truncated; restoring steps.
// ----------------------------------------------------------------------------
module ptd_div import ptd_pkg::*; (
  input  logic               clk,
  input  logic [DIV_NST-1:0] en,
  input  div_in_t            din,
  output logic [QW-1:0]      quo
);

  logic          zero_r [DIV_NST];
  logic          one_r  [DIV_NST];
  logic [WW-1:0] rem_r  [DIV_NST];
  logic [WW-1:0] den_r  [DIV_NST];
  logic [QF-1:0] q_r    [DIV_NST];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zero_r[0] <= (din.num <= 0);
      one_r[0]  <= (din.den <= din.num);
      rem_r[0]  <= din.num;
      den_r[0]  <= din.den;
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k < DIV_NST; k++) begin : g_step
    logic [WW-1:0] rem_nxt;
    logic [QF-1:0] q_nxt;

    always_comb begin
      rem_nxt = rem_r[k-1];
      q_nxt   = q_r[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_nxt = rem_nxt << 1;
        q_nxt   = q_nxt << 1;
        if (rem_nxt >= den_r[k-1]) begin
          rem_nxt  = rem_nxt - den_r[k-1];
          q_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= q_nxt;
      end
    end
  end

  assign quo = zero_r[DIV_NST-1] ? '0 :
               one_r[DIV_NST-1]  ? PONE : {1'b0, q_r[DIV_NST-1]};

endmodule

// ===== sv/ptd_sqrt.sv =====
// ----------------------------------------------------------------------------
// ptd_sqrt: pipelined integer square root
// Floor root of the squared distance, two result bits per stage (one in the last).
// ----------------------------------------------------------------------------
module ptd_sqrt import ptd_pkg::*; (
  input  logic                clk,
  input  logic [SQRT_NST-1:0] en,
  input  logic [SQ_XW-1:0]    x_in,
  output logic [SQ_IT-1:0]    root
);

  logic [SQ_XW-1:0] x_r [SQRT_NST];
  logic [SQ_RW-1:0] r_r [SQRT_NST];

  for (genvar k = 0; k < SQRT_NST; k++) begin : g_step
    logic [SQ_XW-1:0] xs;
    logic [SQ_RW-1:0] rs;
    logic [SQ_XW-1:0] x_nxt;
    logic [SQ_RW-1:0] r_nxt;
    logic [SQ_RW-1:0] b;
    logic [SQ_RW-1:0] rb;

    if (k == 0) begin : g_first
      assign xs = x_in;
      assign rs = '0;
    end else begin : g_next
      assign xs = x_r[k-1];
      assign rs = r_r[k-1];
    end

    always_comb begin
      x_nxt = xs;
      r_nxt = rs;
      b     = '0;
      rb    = '0;
      for (int j = 0; j < SQ_STEPS; j++) begin
        if (k * SQ_STEPS + j < SQ_IT) begin
          b  = SQ_RW'(1) << (2 * (SQ_IT - 1 - (k * SQ_STEPS + j)));
          rb = r_nxt + b;
          if ({1'b0, x_nxt} >= rb) begin
            x_nxt = x_nxt - SQ_XW'(rb);
            r_nxt = (r_nxt >> 1) + b;
          end else begin
            r_nxt = r_nxt >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_r[k] <= x_nxt;
        r_r[k] <= r_nxt;
      end
    end
  end

  assign root = r_r[SQRT_NST-1][SQ_IT-1:0];

endmodule

// ===== sv/point_triangle_distance.sv =====
// ----------------------------------------------------------------------------
// point_triangle_distance: closest point on a triangle to a query point
//
// Input beat: three vertices and a query point, signed Q12.12. Output beat:
// closest point, clamped parameters s and t (Q1.16), region 0..6, the
// degenerate flag, squared distance (Q26.24) and distance (Q14.12).
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low.
// The pipeline is 34 register stages deep; while out_stall is low, one beat per
// cycle is accepted and delivered. Depth is set by the split wide multiplies,
// the two 16-step dividers (two steps per stage) and the 25-step square root
// (two steps per stage).
// Each stage holds its beat when the stage after it is full and stalled, so
// bubbles close up; in_stall rises only when every stage up to the input is
// occupied. When out_stall is held the output beat stays unchanged.
// Reset empties all stages; data registers are not cleared.
// ----------------------------------------------------------------------------
module point_triangle_distance import ptd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int MP_AC = 0;
  localparam int MP_BB = 1;
  localparam int MP_BE = 2;
  localparam int MP_CD = 3;
  localparam int MP_BD = 4;
  localparam int MP_AE = 5;
  localparam int SUMW  = QW + 1;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] en;

  // flow control
  assign en[LAST] = !vld_r[LAST] || !out_stall;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  assign vld_nxt = (en & {vld_r[NST-2:0], in_valid}) | (~en & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[ST_IN];
  assign out_valid = vld_r[LAST];

  // input stage: edges and offset
  geo_t               geo_r [ST_IN:ST_CLOSE];
  geo_t               geo_nxt;
  logic [2:0][CW-1:0] v1_in;
  logic [2:0][CW-1:0] v2_in;

  always_comb begin
    geo_nxt.v0 = {in_data.v0_z, in_data.v0_y, in_data.v0_x};
    geo_nxt.q  = {in_data.query_z, in_data.query_y, in_data.query_x};
    v1_in      = {in_data.v1_z, in_data.v1_y, in_data.v1_x};
    v2_in      = {in_data.v2_z, in_data.v2_y, in_data.v2_x};
    for (int i = 0; i < 3; i++) begin
      geo_nxt.e0[i] = EW'($signed(v1_in[i])) - EW'($signed(geo_nxt.v0[i]));
      geo_nxt.e1[i] = EW'($signed(v2_in[i])) - EW'($signed(geo_nxt.v0[i]));
      geo_nxt.w[i]  = EW'($signed(geo_nxt.v0[i])) - EW'($signed(geo_nxt.q[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_IN]) geo_r[ST_IN] <= geo_nxt;
  end

  for (genvar k = ST_IN + 1; k <= ST_CLOSE; k++) begin : g_geo
    always_ff @(posedge clk) begin
      if (en[k]) geo_r[k] <= geo_r[k-1];
    end
  end

  // dot product terms
  prod_t prod_r;
  prod_t prod_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt.a[i] = smul(geo_r[ST_IN].e0[i], geo_r[ST_IN].e0[i]);
      prod_nxt.b[i] = smul(geo_r[ST_IN].e0[i], geo_r[ST_IN].e1[i]);
      prod_nxt.c[i] = smul(geo_r[ST_IN].e1[i], geo_r[ST_IN].e1[i]);
      prod_nxt.d[i] = smul(geo_r[ST_IN].e0[i], geo_r[ST_IN].w[i]);
      prod_nxt.e[i] = smul(geo_r[ST_IN].e1[i], geo_r[ST_IN].w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) prod_r <= prod_nxt;
  end

  dot_t dot_r;

  always_ff @(posedge clk) begin
    if (en[ST_DOT]) begin
      dot_r.a <= sum3(prod_r.a);
      dot_r.b <= sum3(prod_r.b);
      dot_r.c <= sum3(prod_r.c);
      dot_r.d <= sum3(prod_r.d);
      dot_r.e <= sum3(prod_r.e);
    end
  end

  // wide products in partial halves, plus small region terms
  part_t part_r [6];
  aux_t  aux_r  [ST_PART:ST_NUM];
  aux_t  aux_nxt;

  always_comb begin
    aux_nxt.a      = dot_r.a;
    aux_nxt.c      = dot_r.c;
    aux_nxt.nd     = -dot_r.d;
    aux_nxt.ne     = -dot_r.e;
    aux_nxt.dneg   = dot_r.d[DW-1];
    aux_nxt.den2   = SW'(dot_r.a) - (SW'(dot_r.b) <<< 1) + SW'(dot_r.c);
    aux_nxt.r2_df  = (SW'(dot_r.c) + SW'(dot_r.e)) - (SW'(dot_r.b) + SW'(dot_r.d));
    aux_nxt.r2_gt  = aux_nxt.r2_df > 0;
    aux_nxt.r2_le0 = (SW'(dot_r.c) + SW'(dot_r.e)) <= 0;
    aux_nxt.r6_df  = (SW'(dot_r.a) + SW'(dot_r.d)) - (SW'(dot_r.b) + SW'(dot_r.e));
    aux_nxt.r6_gt  = aux_nxt.r6_df > 0;
    aux_nxt.r6_le0 = (SW'(dot_r.a) + SW'(dot_r.d)) <= 0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_PART]) begin
      part_r[MP_AC]  <= mul_part(dot_r.a, dot_r.c);
      part_r[MP_BB]  <= mul_part(dot_r.b, dot_r.b);
      part_r[MP_BE]  <= mul_part(dot_r.b, dot_r.e);
      part_r[MP_CD]  <= mul_part(dot_r.c, dot_r.d);
      part_r[MP_BD]  <= mul_part(dot_r.b, dot_r.d);
      part_r[MP_AE]  <= mul_part(dot_r.a, dot_r.e);
      aux_r[ST_PART] <= aux_nxt;
    end
  end

  for (genvar k = ST_PART + 1; k <= ST_NUM; k++) begin : g_aux
    always_ff @(posedge clk) begin
      if (en[k]) aux_r[k] <= aux_r[k-1];
    end
  end

  logic signed [WW-1:0] wide_r [6];

  always_ff @(posedge clk) begin
    if (en[ST_WIDE]) begin
      for (int i = 0; i < 6; i++) wide_r[i] <= mul_join(part_r[i]);
    end
  end

  num_t num_r;

  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      num_r.det <= wide_r[MP_AC] - wide_r[MP_BB];
      num_r.sn  <= wide_r[MP_BE] - wide_r[MP_CD];
      num_r.tn  <= wide_r[MP_BD] - wide_r[MP_AE];
    end
  end

  // region classification and divider operands
  cls_t                 cls_r [ST_CLS:ST_ST-1];
  cls_t                 cls_nxt;
  div_in_t              dvs_r;
  div_in_t              dvt_r;
  div_in_t              dvs_nxt;
  div_in_t              dvt_nxt;
  div_in_t              div_zero;
  div_in_t              div_one;
  div_in_t              div_da;
  div_in_t              div_ec;
  logic signed [WW-1:0] sum_st;
  aux_t                 ax;

  always_comb begin
    ax          = aux_r[ST_NUM];
    div_zero    = '{num: '0, den: WW'(1)};
    div_one     = '{num: WW'(1), den: WW'(1)};
    div_da      = '{num: WW'(ax.nd), den: WW'(ax.a)};
    div_ec      = '{num: WW'(ax.ne), den: WW'(ax.c)};
    sum_st      = num_r.sn + num_r.tn;
    dvs_nxt     = div_zero;
    dvt_nxt     = div_zero;
    cls_nxt     = '{region: RG_FACE, degen: 1'b0, s_comp: 1'b0, t_comp: 1'b0};
    if (!(sum_st > num_r.det)) begin
      if (num_r.sn < 0) begin
        if (num_r.tn < 0) begin
          cls_nxt.region = RG_VERT0;
          if (ax.dneg) dvs_nxt = div_da;
          else dvt_nxt = div_ec;
        end else begin
          cls_nxt.region = RG_EDGE_S0;
          dvt_nxt = div_ec;
        end
      end else if (num_r.tn < 0) begin
        cls_nxt.region = RG_EDGE_T0;
        dvs_nxt = div_da;
      end else begin
        cls_nxt.region = RG_FACE;
        if (num_r.det == 0) begin
          cls_nxt.degen = 1'b1;
        end else begin
          dvs_nxt = '{num: num_r.sn, den: num_r.det};
          dvt_nxt = '{num: num_r.tn, den: num_r.det};
        end
      end
    end else if (num_r.sn < 0) begin
      cls_nxt.region = RG_VERT2;
      if (ax.r2_gt) begin
        dvs_nxt        = '{num: WW'(ax.r2_df), den: WW'(ax.den2)};
        cls_nxt.t_comp = 1'b1;
      end else begin
        dvt_nxt = ax.r2_le0 ? div_one : div_ec;
      end
    end else if (num_r.tn < 0) begin
      cls_nxt.region = RG_VERT1;
      if (ax.r6_gt) begin
        dvt_nxt        = '{num: WW'(ax.r6_df), den: WW'(ax.den2)};
        cls_nxt.s_comp = 1'b1;
      end else begin
        dvs_nxt = ax.r6_le0 ? div_one : div_da;
      end
    end else begin
      cls_nxt.region = RG_EDGE_ST;
      dvs_nxt        = '{num: WW'(ax.r2_df), den: WW'(ax.den2)};
      cls_nxt.t_comp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CLS]) begin
      cls_r[ST_CLS] <= cls_nxt;
      dvs_r         <= dvs_nxt;
      dvt_r         <= dvt_nxt;
    end
  end

  for (genvar k = ST_CLS + 1; k < ST_ST; k++) begin : g_cls
    always_ff @(posedge clk) begin
      if (en[k]) cls_r[k] <= cls_r[k-1];
    end
  end

  logic [QW-1:0] quo_s;
  logic [QW-1:0] quo_t;

  ptd_div u_div_s (
    .clk (clk),
    .en  (en[ST_DIV0 +: DIV_NST]),
    .din (dvs_r),
    .quo (quo_s)
  );

  ptd_div u_div_t (
    .clk (clk),
    .en  (en[ST_DIV0 +: DIV_NST]),
    .din (dvt_r),
    .quo (quo_t)
  );

  // result beat travels from here to the output
  out_t tail_r   [ST_ST:LAST];
  out_t tail_nxt [ST_ST:LAST];
  cls_t cl_last;

  always_comb begin
    cl_last                     = cls_r[ST_ST-1];
    tail_nxt[ST_ST]             = '0;
    tail_nxt[ST_ST].param_s     = cl_last.s_comp ? PONE - quo_t : quo_s;
    tail_nxt[ST_ST].param_t     = cl_last.t_comp ? PONE - quo_s : quo_t;
    tail_nxt[ST_ST].region      = cl_last.region;
    tail_nxt[ST_ST].degenerate  = cl_last.degen;
  end

  // closest point
  logic [2:0][PMW-1:0]    ps_r;
  logic [2:0][PMW-1:0]    pt_r;
  logic signed [PSW-1:0]  acc;
  logic signed [PSW-1:0]  rnd;
  logic [2:0][CW-1:0]     cl_nxt;

  always_ff @(posedge clk) begin
    if (en[ST_PMUL]) begin
      for (int i = 0; i < 3; i++) begin
        ps_r[i] <= PMW'($signed(geo_r[ST_ST].e0[i]) * $signed({1'b0, tail_r[ST_ST].param_s}));
        pt_r[i] <= PMW'($signed(geo_r[ST_ST].e1[i]) * $signed({1'b0, tail_r[ST_ST].param_t}));
      end
    end
  end

  always_comb begin
    acc = '0;
    rnd = '0;
    for (int i = 0; i < 3; i++) begin
      acc = (PSW'($signed(geo_r[ST_PMUL].v0[i])) <<< QF) + PSW'($signed(ps_r[i]))
          + PSW'($signed(pt_r[i])) + (PSW'(1) <<< (QF - 1));
      rnd = acc >>> QF;
      if (rnd < -(PSW'(1) <<< (CW - 1))) begin
        cl_nxt[i] = {1'b1, {(CW-1){1'b0}}};
      end else if (rnd > (PSW'(1) <<< (CW - 1)) - PSW'(1)) begin
        cl_nxt[i] = {1'b0, {(CW-1){1'b1}}};
      end else begin
        cl_nxt[i] = rnd[CW-1:0];
      end
    end
  end

  // squared distance
  logic [2:0][SQW-1:0] sq_r;
  logic [2:0][CW-1:0]  cl_q;

  assign cl_q = {tail_r[ST_CLOSE].closest_z, tail_r[ST_CLOSE].closest_y,
                 tail_r[ST_CLOSE].closest_x};

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQW'(smul(EW'($signed(geo_r[ST_CLOSE].q[i])) - EW'($signed(cl_q[i])),
                             EW'($signed(geo_r[ST_CLOSE].q[i])) - EW'($signed(cl_q[i]))));
      end
    end
  end

  for (genvar k = ST_ST + 1; k <= LAST; k++) begin : g_tail
    always_comb begin
      tail_nxt[k] = tail_r[k-1];
      if (k == ST_CLOSE) begin
        tail_nxt[k].closest_x = cl_nxt[0];
        tail_nxt[k].closest_y = cl_nxt[1];
        tail_nxt[k].closest_z = cl_nxt[2];
      end
      if (k == ST_SUM) begin
        tail_nxt[k].distance_sq = DSQW'(sq_r[0]) + DSQW'(sq_r[1]) + DSQW'(sq_r[2]);
      end
    end
  end

  for (genvar k = ST_ST; k <= LAST; k++) begin : g_tail_reg
    always_ff @(posedge clk) begin
      if (en[k]) tail_r[k] <= tail_nxt[k];
    end
  end

  logic [SQ_IT-1:0] root;

  ptd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en[ST_SQRT0 +: SQRT_NST]),
    .x_in (tail_r[ST_SUM].distance_sq),
    .root (root)
  );

  always_comb begin
    out_data          = tail_r[LAST];
    out_data.distance = DISTW'(root);
  end

  a_st_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (SUMW'(out_data.param_s) + SUMW'(out_data.param_t)) <= SUMW'(PONE))
    else $error("s + t exceeds one");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.region == RG_FACE && out_data.param_s == '0 && out_data.param_t == '0)
    else $error("degenerate beat not on face with zero parameters");

  a_root_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DSQW'(out_data.distance) * DSQW'(out_data.distance))
                  <= out_data.distance_sq)
    else $error("distance too large for distance_sq");

  a_root_hi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((DSQW'(out_data.distance) + DSQW'(1)) *
                   (DSQW'(out_data.distance) + DSQW'(1))) > out_data.distance_sq)
    else $error("distance too small for distance_sq");

  a_in_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[ST_IN] && vld_r[LAST])
    else $error("input stalled with a free pipeline slot");

endmodule
